>>> design/topological_sort_kahn_defines.svh
// Assertion macros shared by the checker files of the topological sort block.
`ifndef TOPOLOGICAL_SORT_KAHN_DEFINES_SVH
`define TOPOLOGICAL_SORT_KAHN_DEFINES_SVH

// The condition must hold at every rising edge while out of reset.
`define TSK_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/tsk_pkg.sv
// Package with the types and constants of the topological sort block.
package tsk_pkg;

    // Number of rows of the adjacency matrix and entries of the ready queue.
    localparam int SPAN = 16;
    // Width of a vertex number and of a count that can hold SPAN itself.
    localparam int VW = 4;
    localparam int CW = 5;
    // Vertex count after reset.
    localparam logic [CW-1:0] VCOUNT_RESET = 5'd16;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_LOAD = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_POP  = 5'b00100,
        ST_REL  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // Requests from the sequencer to the ready queue.
    typedef struct packed {
        logic          push;
        logic          pop;
        logic [VW-1:0] data;
    } q_ctrl_t;

    // Status of the ready queue.
    typedef struct packed {
        logic          empty;
        logic [VW-1:0] head;
    } q_stat_t;

endpackage

>>> design/tsk_queue.sv
// Ready queue of the topological sort: a small FIFO of vertex numbers.
module tsk_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  tsk_pkg::q_ctrl_t ctrl,
    output tsk_pkg::q_stat_t stat
);

    logic [tsk_pkg::VW-1:0] entry_reg [tsk_pkg::SPAN];
    logic [tsk_pkg::VW-1:0] head_reg;
    logic [tsk_pkg::VW-1:0] head_next;
    logic [tsk_pkg::VW-1:0] tail_reg;
    logic [tsk_pkg::VW-1:0] tail_next;
    logic [tsk_pkg::CW-1:0] count_reg;
    logic [tsk_pkg::CW-1:0] count_next;

    // Entries hold no meaning until written, so they carry no reset.
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            entry_reg[tail_reg] <= ctrl.data;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctrl.push)
        begin
            tail_next = tail_reg + 1'b1;
        end
        if (ctrl.pop)
        begin
            head_next = head_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign stat.empty = (count_reg == '0);
    assign stat.head  = entry_reg[head_reg];

endmodule

>>> design/topological_sort_kahn.sv
// Top level of the topological sort block: edge loading and Kahn's sort sequencer.
//
//  Channel  Dir  Beat contents
//  -------  ---  -------------------------------------------------------------
//  s_*      in   tdata: edge_to, edge_from; tuser: has_edge; tlast: last_item
//  m_*      out  tdata: vertex; tuser: vertex_valid, cycle_found; tlast: last
//  cfg_*    in   cfg_wdata: vertex_count, written when cfg_we is high
//
// Edge beats are taken one per cycle. The beat marked tlast starts the sort,
// and s_tready stays low until the sort has finished: the initial scan over
// n indices, then a pop and a pass over n indices for every vertex taken from
// the ready queue, a step to find the queue empty and the close, which first
// sends any held vertex when a cycle is reported, where n is the clamped
// vertex count; a result beat held on m_tready adds its wait. Every pass goes
// through the one in-degree decrement and zero test, one index per cycle.
// The result register lets the sequencer run on while one beat waits on
// m_tready; it stalls only when a second result is due.
// Reset (rst_n, asynchronous, active low) clears the matrix, the in-degree
// counters and all control state; the matrix and counters are also cleared in
// the closing cycle of every sort.
module topological_sort_kahn #(
    parameter int MAX_VERTICES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input beats.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] edge_to, [7:4] edge_from
    input  logic [0:0]  s_tuser,   // [0] has_edge
    input  logic        s_tlast,
    // Result beats.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [3:0] vertex, [7:4] zero
    output logic [1:0]  m_tuser,   // [0] vertex_valid, [1] cycle_found
    output logic        m_tlast,
    // Vertex count register.
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata
);

    localparam int VW = tsk_pkg::VW;
    localparam int CW = tsk_pkg::CW;
    localparam int SPAN = tsk_pkg::SPAN;
    // Highest number of vertices that the matrix can take part in the sort.
    localparam int LIMIT = (MAX_VERTICES < SPAN) ? MAX_VERTICES : SPAN;
    localparam logic [CW-1:0] LIMIT_V = CW'(LIMIT);

    tsk_pkg::state_t  state_reg;
    tsk_pkg::state_t  state_next;
    tsk_pkg::q_ctrl_t q_ctrl;
    tsk_pkg::q_stat_t q_stat;

    logic [SPAN-1:0] adj_reg   [SPAN];
    logic [CW-1:0]   indeg_reg [SPAN];

    logic [CW-1:0] vcount_reg;
    logic [VW-1:0] idx_reg;
    logic [VW-1:0] idx_next;
    logic [CW-1:0] emitted_reg;
    logic [CW-1:0] emitted_next;
    logic          hold_valid_reg;
    logic          hold_valid_next;
    logic [VW-1:0] hold_v_reg;
    logic [VW-1:0] hold_v_next;

    logic          out_valid_reg;
    logic [VW-1:0] out_vertex_reg;
    logic          out_vvalid_reg;
    logic          out_cycle_reg;
    logic          out_last_reg;

    logic [VW-1:0] edge_to;
    logic [VW-1:0] edge_from;
    logic          load_fire;
    logic          edge_ok;
    logic          new_edge;
    logic [VW-1:0] row_addr;
    logic [SPAN-1:0] row_val;
    logic [VW-1:0] deg_addr;
    logic [CW-1:0] deg_val;
    logic [CW-1:0] n_eff;
    logic [VW-1:0] n_m1;
    logic          idx_end;
    logic          out_free;

    // Sequencer commands.
    logic          adj_set;
    logic          deg_wr;
    logic [CW-1:0] deg_wdata;
    logic          clear_all;
    logic          out_load;
    logic [VW-1:0] out_vertex_new;
    logic          out_vvalid_new;
    logic          out_cycle_new;
    logic          out_last_new;

    assign edge_to   = s_tdata[3:0];
    assign edge_from = s_tdata[7:4];
    assign s_tready  = (state_reg == tsk_pkg::ST_LOAD);
    assign load_fire = s_tvalid && s_tready;

    // Edges that name a vertex beyond the matrix are dropped.
    assign edge_ok = s_tuser[0] && ({1'b0, edge_from} < LIMIT_V)
                     && ({1'b0, edge_to} < LIMIT_V);

    // One matrix row and one in-degree counter are read per cycle; the address
    // comes from the beat while loading and from the sequencer while sorting.
    assign row_addr = s_tready ? edge_from : hold_v_reg;
    assign row_val  = adj_reg[row_addr];
    assign deg_addr = s_tready ? edge_to : idx_reg;
    assign deg_val  = indeg_reg[deg_addr];
    assign new_edge = edge_ok && !row_val[edge_to];

    // A vertex count of zero is taken as one, and counts above the matrix size
    // are lowered to it.
    always_comb
    begin
        if (vcount_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (vcount_reg > LIMIT_V)
        begin
            n_eff = LIMIT_V;
        end
        else
        begin
            n_eff = vcount_reg;
        end
    end

    assign n_m1     = VW'(n_eff - CW'(1));
    assign idx_end  = (idx_reg == n_m1);
    assign out_free = !out_valid_reg || m_tready;

    // Sequencer. The vertex most recently taken from the queue is held back
    // until it is known whether it is the final result of the sort.
    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        emitted_next    = emitted_reg;
        hold_valid_next = hold_valid_reg;
        hold_v_next     = hold_v_reg;
        q_ctrl          = '0;
        q_ctrl.data     = idx_reg;
        adj_set         = 1'b0;
        deg_wr          = 1'b0;
        deg_wdata       = deg_val;
        clear_all       = 1'b0;
        out_load        = 1'b0;
        out_vertex_new  = hold_v_reg;
        out_vvalid_new  = 1'b1;
        out_cycle_new   = 1'b0;
        out_last_new    = 1'b0;

        case (state_reg)
            tsk_pkg::ST_LOAD:
            begin
                if (load_fire)
                begin
                    if (new_edge)
                    begin
                        adj_set   = 1'b1;
                        deg_wr    = 1'b1;
                        deg_wdata = CW'(deg_val + CW'(1));
                    end
                    if (s_tlast)
                    begin
                        state_next      = tsk_pkg::ST_SCAN;
                        idx_next        = '0;
                        emitted_next    = '0;
                        hold_valid_next = 1'b0;
                    end
                end
            end

            // Queue every vertex that starts with no predecessor, in index order.
            tsk_pkg::ST_SCAN:
            begin
                q_ctrl.push = (deg_val == '0);
                idx_next    = idx_reg + 1'b1;
                if (idx_end)
                begin
                    state_next = tsk_pkg::ST_POP;
                end
            end

            tsk_pkg::ST_POP:
            begin
                if (q_stat.empty)
                begin
                    state_next = tsk_pkg::ST_DONE;
                end
                else if (!hold_valid_reg || out_free)
                begin
                    out_load        = hold_valid_reg;
                    q_ctrl.pop      = 1'b1;
                    hold_v_next     = q_stat.head;
                    hold_valid_next = 1'b1;
                    emitted_next    = emitted_reg + 1'b1;
                    idx_next        = '0;
                    state_next      = tsk_pkg::ST_REL;
                end
            end

            // Remove the held vertex: lower each successor and queue the ones
            // that reach zero.
            tsk_pkg::ST_REL:
            begin
                if (row_val[idx_reg] && (deg_val != '0))
                begin
                    deg_wr      = 1'b1;
                    deg_wdata   = deg_val - 1'b1;
                    q_ctrl.push = (deg_val == CW'(1));
                end
                idx_next = idx_reg + 1'b1;
                if (idx_end)
                begin
                    state_next = tsk_pkg::ST_POP;
                end
            end

            tsk_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (emitted_reg == n_eff)
                    begin
                        out_last_new    = 1'b1;
                        hold_valid_next = 1'b0;
                        clear_all       = 1'b1;
                        state_next      = tsk_pkg::ST_LOAD;
                    end
                    else if (hold_valid_reg)
                    begin
                        hold_valid_next = 1'b0;
                    end
                    else
                    begin
                        // Some vertices were never freed: report the cycle.
                        out_vertex_new = '0;
                        out_vvalid_new = 1'b0;
                        out_cycle_new  = 1'b1;
                        out_last_new   = 1'b1;
                        clear_all      = 1'b1;
                        state_next     = tsk_pkg::ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = tsk_pkg::ST_LOAD;
            end
        endcase
    end

    tsk_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (q_ctrl),
        .stat  (q_stat)
    );

    // Adjacency matrix and in-degree counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < SPAN; r++)
            begin
                adj_reg[r]   <= '0;
                indeg_reg[r] <= '0;
            end
        end
        else if (clear_all)
        begin
            for (int r = 0; r < SPAN; r++)
            begin
                adj_reg[r]   <= '0;
                indeg_reg[r] <= '0;
            end
        end
        else
        begin
            if (adj_set)
            begin
                adj_reg[edge_from][edge_to] <= 1'b1;
            end
            if (deg_wr)
            begin
                indeg_reg[deg_addr] <= deg_wdata;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tsk_pkg::ST_LOAD;
            vcount_reg     <= tsk_pkg::VCOUNT_RESET;
            idx_reg        <= '0;
            emitted_reg    <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            emitted_reg    <= emitted_next;
            hold_valid_reg <= hold_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hold_v_reg <= hold_v_next;
        if (out_load)
        begin
            out_vertex_reg <= out_vertex_new;
            out_vvalid_reg <= out_vvalid_new;
            out_cycle_reg  <= out_cycle_new;
            out_last_reg   <= out_last_new;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_vertex_reg};
    assign m_tuser  = {out_cycle_reg, out_vvalid_reg};
    assign m_tlast  = out_last_reg;

endmodule

>>> design/tsk_checker.sv
// Port checker for the topological sort block, bound to its top level.
`include "topological_sort_kahn_defines.svh"

module tsk_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result beat keeps its contents.
    `TSK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
        "result beat changed while stalled")

    // Every result is either an ordered vertex or the cycle report.
    `TSK_ASSERT_ALWAYS(a_out_kind, !m_tvalid || (m_tuser[0] != m_tuser[1]),
        "result beat is neither a vertex nor a cycle report")

    // The cycle report closes the sort and carries vertex zero.
    `TSK_ASSERT_ALWAYS(a_cycle_last,
        !(m_tvalid && m_tuser[1]) || (m_tlast && (m_tdata[3:0] == 4'd0)),
        "cycle report without last or with a vertex")

    // The beat that ends a graph starts the sort, so loading pauses.
    `TSK_ASSERT_NEXT(a_sort_stall, s_tvalid && s_tready && s_tlast, !s_tready,
        "input still ready after the final load beat")

endmodule

bind topological_sort_kahn tsk_checker u_tsk_checker (.*);

>>> test/tb.sv
// Self-checking testbench for the Kahn topological sort block.
`timescale 1ns / 1ps

module tb;

    localparam int NV          = tsk_pkg::SPAN;
    localparam int SETTLE      = 8;       // cycles allowed for the closing cycle of a sort
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 370;
    localparam int QUIET_TAIL  = 60;      // final beats sent with no idling on either side
    localparam int REPORT_MAX  = 10;

    // One beat of the sorted order as it should leave the block.
    typedef struct packed {
        logic [3:0] vertex;
        logic       listed;
        logic       cyclic;
        logic       closing;
    } order_beat_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [0:0]  s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic [4:0]  cfg_wdata;

    // Predicted graph state and the queue of expected order beats.
    order_beat_t    expected_order [$];
    logic [NV-1:0]  arc_rows [NV];
    int unsigned    pred_count [NV];
    logic [4:0]     vertex_count_reg;

    int error_count = 0;
    int item_count  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit sender_gaps     = 1'b0;
    bit receiver_stalls = 1'b0;

    topological_sort_kahn #(
        .MAX_VERTICES(NV)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("[topological_sort_kahn] ERROR");
            $finish;
        end
    end

    // Receiver back-pressure: stall bursts of random length, when enabled.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready = 1'b0;
            stall_left--;
        end
        else if (receiver_stalls && $urandom_range(0, 4) == 0)
        begin
            m_tready = 1'b0;
            stall_left = $urandom_range(0, 3);
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    function automatic int sorted_span();
        if (vertex_count_reg == 0)
            return 1;
        if (vertex_count_reg > NV)
            return NV;
        return int'(vertex_count_reg);
    endfunction

    function automatic void clear_graph();
        for (int i = 0; i < NV; i++)
        begin
            arc_rows[i] = '0;
            pred_count[i] = 0;
        end
    endfunction

    // Applies one accepted input beat to the predicted graph; a beat marked
    // last also runs the sort and queues the order beats it produces.
    task automatic sort_graph(input logic [3:0] to, input logic [3:0] from,
                              input bit has_arc, input bit closes);
        int n;
        int v;
        int emitted;
        int ready [$];
        order_beat_t beat;
        begin
            // A repeated arc must not raise the in-degree a second time.
            if (has_arc && !arc_rows[from][to])
            begin
                arc_rows[from][to] = 1'b1;
                pred_count[to]++;
            end
            if (closes)
            begin
                n = sorted_span();
                emitted = 0;
                for (int i = 0; i < n; i++)
                    if (pred_count[i] == 0)
                        ready.push_back(i);
                while (ready.size() != 0)
                begin
                    v = ready.pop_front();
                    beat = '{vertex: v[3:0], listed: 1'b1, cyclic: 1'b0, closing: 1'b0};
                    expected_order.push_back(beat);
                    emitted++;
                    // Only successors inside the sorted range are released.
                    for (int i = 0; i < n; i++)
                        if (arc_rows[v][i] && pred_count[i] != 0)
                        begin
                            pred_count[i]--;
                            if (pred_count[i] == 0)
                                ready.push_back(i);
                        end
                end
                if (emitted != n)
                begin
                    beat = '{vertex: 4'd0, listed: 1'b0, cyclic: 1'b1, closing: 1'b1};
                    expected_order.push_back(beat);
                end
                else
                begin
                    beat = expected_order.pop_back();
                    beat.closing = 1'b1;
                    expected_order.push_back(beat);
                end
                clear_graph();
            end
        end
    endtask

    // Drives one input beat from the falling edge and waits for its handshake.
    task automatic send_beat(input logic [3:0] to, input logic [3:0] from,
                             input bit has_arc, input bit closes);
        begin
            @(negedge clk);
            if (sender_gaps && $urandom_range(0, 3) == 0)
            begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 4)) @(negedge clk);
            end
            s_tvalid = 1'b1;
            s_tdata  = {from, to};
            s_tuser  = has_arc;
            s_tlast  = closes;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            item_count++;
            sort_graph(to, from, has_arc, closes);
        end
    endtask

    // Holds the sender off until every expected beat has arrived and the
    // block has had time to finish its closing cycle.
    task automatic drain_results();
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tlast  = 1'b0;
            while (expected_order.size() != 0)
                @(posedge clk);
            repeat (SETTLE) @(posedge clk);
        end
    endtask

    task automatic write_vertex_count(input logic [4:0] value);
        begin
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_wdata = value;
            @(negedge clk);
            cfg_we = 1'b0;
            vertex_count_reg = value;
        end
    endtask

    // Each accepted result beat is compared with the oldest expected one.
    always @(posedge clk)
    begin : result_check
        order_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_order.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_MAX)
                    $display("unexpected beat: vertex %0d valid %0b cycle %0b tlast %0b",
                             m_tdata[3:0], m_tuser[0], m_tuser[1], m_tlast);
            end
            else
            begin
                want = expected_order.pop_front();
                if (m_tdata[3:0] !== want.vertex || m_tuser[0] !== want.listed ||
                    m_tuser[1] !== want.cyclic || m_tlast !== want.closing)
                begin
                    error_count++;
                    if (error_count <= REPORT_MAX)
                        $display({"mismatch: expected vertex %0d valid %0b cycle %0b tlast %0b,",
                                  " got vertex %0d valid %0b cycle %0b tlast %0b"},
                                 want.vertex, want.listed, want.cyclic, want.closing,
                                 m_tdata[3:0], m_tuser[0], m_tuser[1], m_tlast);
                end
            end
        end
    end

    // A graph with no arcs at all comes out in plain index order.
    task automatic test_empty_graph();
        begin
            send_beat(4'hF, 4'hA, 1'b0, 1'b0);
            send_beat(4'h0, 4'h0, 1'b0, 1'b1);
        end
    endtask

    // Arcs between the lowest and highest vertex form a two-vertex cycle.
    task automatic test_field_extremes();
        begin
            send_beat(4'h0, 4'hF, 1'b1, 1'b0);
            send_beat(4'hF, 4'h0, 1'b1, 1'b0);
            send_beat(4'h5, 4'h9, 1'b0, 1'b1);
        end
    endtask

    // The same arc twice is counted once; the closing beat carries an arc.
    task automatic test_repeated_arc();
        begin
            send_beat(4'd5, 4'd3, 1'b1, 1'b0);
            send_beat(4'd5, 4'd3, 1'b1, 1'b0);
            send_beat(4'd7, 4'd5, 1'b1, 1'b0);
            send_beat(4'd7, 4'd3, 1'b1, 1'b1);
        end
    endtask

    task automatic test_self_loop();
        begin
            drain_results();
            write_vertex_count(5'd8);
            send_beat(4'd2, 4'd2, 1'b1, 1'b0);
            send_beat(4'd4, 4'd1, 1'b1, 1'b1);
        end
    endtask

    // An arc from outside the sorted range blocks its destination, while an
    // arc leading out of the range is harmless.
    task automatic test_outside_range();
        begin
            drain_results();
            write_vertex_count(5'd4);
            send_beat(4'd1, 4'd6, 1'b1, 1'b0);
            send_beat(4'd9, 4'd1, 1'b1, 1'b0);
            send_beat(4'd3, 4'd0, 1'b1, 1'b1);
        end
    endtask

    // A count of zero sorts one vertex, counts above sixteen are clamped.
    task automatic test_count_limits();
        begin
            drain_results();
            write_vertex_count(5'd0);
            send_beat(4'd0, 4'd0, 1'b0, 1'b1);
            drain_results();
            write_vertex_count(5'd1);
            send_beat(4'd0, 4'd0, 1'b1, 1'b1);
            drain_results();
            write_vertex_count(5'd31);
            send_beat(4'd3, 4'd12, 1'b1, 1'b1);
            drain_results();
            write_vertex_count(5'd17);
            send_beat(4'd14, 4'd15, 1'b1, 1'b1);
        end
    endtask

    // Mostly acyclic graphs built along a shuffled vertex ranking, mixed with
    // repeated arcs, arbitrary arcs that may close cycles, and no-arc lines.
    task automatic send_random_graph();
        int n;
        int arcs;
        int a;
        int b;
        int t;
        int kind;
        int rank [NV];
        logic [3:0] to;
        logic [3:0] from;
        logic [3:0] prev_to;
        logic [3:0] prev_from;
        bit has_arc;
        bit has_prev;
        bit closes;
        begin
            n = sorted_span();
            for (int i = 0; i < NV; i++)
                rank[i] = i;
            for (int i = n - 1; i > 0; i--)
            begin
                a = $urandom_range(0, i);
                t = rank[i];
                rank[i] = rank[a];
                rank[a] = t;
            end
            arcs = $urandom_range(0, 12);
            has_prev = 1'b0;
            prev_to = '0;
            prev_from = '0;
            for (int i = 0; i <= arcs; i++)
            begin
                closes = (i == arcs);
                kind = $urandom_range(0, 19);
                has_arc = 1'b1;
                if (kind == 1 && has_prev)
                begin
                    to = prev_to;
                    from = prev_from;
                end
                else if (kind <= 3 || n < 2)
                begin
                    to = 4'($urandom_range(0, 15));
                    from = 4'($urandom_range(0, 15));
                    has_arc = (kind != 0);
                end
                else
                begin
                    a = $urandom_range(0, n - 2);
                    b = $urandom_range(a + 1, n - 1);
                    from = 4'(rank[a]);
                    to = 4'(rank[b]);
                end
                if (closes && $urandom_range(0, 2) == 0)
                    has_arc = 1'b0;
                prev_to = to;
                prev_from = from;
                has_prev = has_arc;
                send_beat(to, from, has_arc, closes);
            end
        end
    endtask

    task automatic test_random_graphs();
        int graph_no;
        logic [4:0] count;
        begin
            graph_no = 0;
            while (item_count < ITEM_TARGET)
            begin
                if (graph_no % 4 == 3)
                begin
                    drain_results();
                    case ($urandom_range(0, 9))
                        0:       count = 5'd0;
                        1:       count = 5'd31;
                        2:       count = 5'd1;
                        3:       count = 5'($urandom_range(17, 31));
                        default: count = 5'($urandom_range(2, 16));
                    endcase
                    write_vertex_count(count);
                end
                if (ITEM_TARGET - item_count < QUIET_TAIL)
                begin
                    sender_gaps = 1'b0;
                    receiver_stalls = 1'b0;
                end
                else
                begin
                    sender_gaps = (graph_no % 5 != 4);
                    receiver_stalls = (graph_no % 7 != 6);
                end
                send_random_graph();
                graph_no++;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        vertex_count_reg = tsk_pkg::VCOUNT_RESET;
        clear_graph();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        sender_gaps = 1'b1;
        receiver_stalls = 1'b1;
        test_empty_graph();
        test_field_extremes();
        test_repeated_arc();
        test_self_loop();
        test_outside_range();
        test_count_limits();
        test_random_graphs();

        drain_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("[topological_sort_kahn] OK");
        else
            $display("[topological_sort_kahn] ERROR");
        $finish;
    end

endmodule
